// ----- hdl/sfrm_pkg.sv -----
package sfrm_pkg;

  localparam int NumStreams   = 3;
  localparam int IntervalW    = 24;
  localparam int AgeW         = 8;
  localparam int TickW        = 16;
  localparam int CfgIndexW    = 3;
  localparam int CfgDataW     = 24;
  localparam int OutDataW     = 16;

  typedef enum logic [1:0] {
    ACT_TICK       = 2'd0,
    ACT_SOLUTION   = 2'd1,
    ACT_CORRECTION = 2'd2,
    ACT_ATTITUDE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RATE_UNKNOWN = 2'd0,
    RATE_OK      = 2'd1,
    RATE_WARNING = 2'd2,
    RATE_ERROR   = 2'd3
  } rate_t;

  localparam logic [CfgIndexW-1:0] REG_EXPECTED_INTERVAL = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_AGE_LIMIT         = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_AGE_CEILING       = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SOLUTION_LIMIT    = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_CORRECTION_LIMIT  = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_ATTITUDE_LIMIT    = 3'd5;

  localparam logic [IntervalW-1:0] RST_EXPECTED_INTERVAL = '0;
  localparam logic [AgeW-1:0]      RST_AGE_LIMIT         = 8'd10;
  localparam logic [AgeW-1:0]      RST_AGE_CEILING       = 8'd255;
  localparam logic [TickW-1:0]     RST_TICK_LIMIT        = 16'd1;

  typedef struct packed {
    logic tick;
    logic arrive;
  } lane_ctrl_t;

  typedef struct packed {
    logic [AgeW-1:0]  age_limit;
    logic [AgeW-1:0]  age_ceiling;
    logic [TickW-1:0] tick_limit;
  } lane_cfg_t;

  typedef struct packed {
    logic missing;
    logic changed;
  } lane_stat_t;

endpackage

// ----- hdl/stream_freshness_rate_monitor.sv -----
// An accepted input word passes the input register, then the result register, to m_tdata.
// Throughput: one word per cycle, m_tready allowing; a word enters while a result waits.
// Every input word gives exactly one result word.
// Reset (rst, synchronous, active high) clears all ages, tick counters and
// missing flags, sets the rate status to unknown and loads register defaults.
module stream_freshness_rate_monitor
  import sfrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IntervalW-1:0] s_tdata,   // [23:0] publish_interval_us
  input  logic [1:0]           s_tuser,   // [1:0] action
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata    // [1:0] rate_status, [2] rate_status_changed,
                                          // [5:3] missing_mask,
                                          // [8:6] missing_changed_mask, [15:9] zero
);

  // Configuration registers
  logic [IntervalW-1:0] expected_interval;
  logic [AgeW-1:0]      age_limit;
  logic [AgeW-1:0]      age_ceiling;
  logic [TickW-1:0]     tick_limit [NumStreams];

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_interval <= RST_EXPECTED_INTERVAL;
      age_limit         <= RST_AGE_LIMIT;
      age_ceiling       <= RST_AGE_CEILING;
      for (int i = 0; i < NumStreams; i++) begin
        tick_limit[i] <= RST_TICK_LIMIT;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPECTED_INTERVAL: expected_interval <= cfg_data;
        REG_AGE_LIMIT:         age_limit         <= cfg_data[AgeW-1:0];
        REG_AGE_CEILING:       age_ceiling       <= cfg_data[AgeW-1:0];
        REG_SOLUTION_LIMIT:    tick_limit[0]     <= cfg_data[TickW-1:0];
        REG_CORRECTION_LIMIT:  tick_limit[1]     <= cfg_data[TickW-1:0];
        REG_ATTITUDE_LIMIT:    tick_limit[2]     <= cfg_data[TickW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input register stage
  logic                 in_valid;
  action_t              in_action;
  logic [IntervalW-1:0] in_interval;
  logic                 out_free;
  logic                 advance;

  // The result register frees when empty or when its word is taken this cycle
  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_action   <= action_t'(s_tuser);
      in_interval <= s_tdata;
    end
  end

  // Rate rating: 2x as interval > 2*expected, 1.3x as 10*interval > 13*expected,
  // all done with shift-adds in widths that cannot overflow.
  logic [IntervalW:0]   twice_expected;
  logic [IntervalW+3:0] interval_x10;
  logic [IntervalW+3:0] expected_x13;
  rate_t                rating;
  rate_t                rate_state;
  logic                 is_tick;

  assign twice_expected = {expected_interval, 1'b0};
  assign interval_x10   = {1'b0, in_interval, 3'b000} + {3'b000, in_interval, 1'b0};
  assign expected_x13   = {1'b0, expected_interval, 3'b000}
                        + {2'b00, expected_interval, 2'b00}
                        + {4'b0000, expected_interval};

  always_comb begin
    if ({1'b0, in_interval} > twice_expected) begin
      rating = RATE_ERROR;
    end else if (interval_x10 > expected_x13) begin
      rating = RATE_WARNING;
    end else if (in_interval == '0) begin
      rating = RATE_UNKNOWN;
    end else begin
      rating = RATE_OK;
    end
  end

  assign is_tick = (in_action == ACT_TICK);

  // Per-stream age, prescale counter and missing flag
  lane_ctrl_t                  lane_ctrl [NumStreams];
  lane_cfg_t                   lane_cfg  [NumStreams];
  lane_stat_t                  lane_stat [NumStreams];
  logic       [NumStreams-1:0] missing_mask;
  logic       [NumStreams-1:0] missing_changed;

  always_comb begin
    lane_ctrl[0].arrive = advance && (in_action == ACT_SOLUTION);
    lane_ctrl[1].arrive = advance && (in_action == ACT_CORRECTION);
    lane_ctrl[2].arrive = advance && (in_action == ACT_ATTITUDE);
    for (int i = 0; i < NumStreams; i++) begin
      lane_ctrl[i].tick       = advance && is_tick;
      lane_cfg[i].age_limit   = age_limit;
      lane_cfg[i].age_ceiling = age_ceiling;
      lane_cfg[i].tick_limit  = tick_limit[i];
      missing_mask[i]         = lane_stat[i].missing;
      missing_changed[i]      = lane_stat[i].changed;
    end
  end

  for (genvar g = 0; g < NumStreams; g++) begin : g_lane
    sfrm_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl[g]),
      .cfg  (lane_cfg[g]),
      .stat (lane_stat[g])
    );
  end

  // Rate state and result register
  rate_t                 rate_next;
  logic                  rate_changed;
  logic [OutDataW-1:0]   result_next;

  assign rate_next    = is_tick ? rating : rate_state;
  assign rate_changed = is_tick && (rating != rate_state);
  assign result_next  = {{(OutDataW - 3 - 2 * NumStreams){1'b0}},
                         missing_changed, missing_mask, rate_changed, rate_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_state <= RATE_UNKNOWN;
      m_tvalid   <= 1'b0;
    end else begin
      if (advance) begin
        rate_state <= rate_next;
      end
      if (out_free) begin
        m_tvalid <= in_valid;
      end
    end
    if (advance) begin
      m_tdata <= result_next;
    end
  end

endmodule

// ----- hdl/sfrm_lane.sv -----
module sfrm_lane
  import sfrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  lane_cfg_t  cfg,
  output lane_stat_t stat
);

  logic [AgeW-1:0]  age;
  logic [TickW-1:0] tick_count;
  logic             missing;
  logic             over_limit;
  logic             expired;

  assign over_limit = (age > cfg.age_limit);
  assign expired    = (tick_count > cfg.tick_limit);

  // Missing flag as it stands after this word
  assign stat.missing = ctrl.tick ? over_limit : missing;
  assign stat.changed = ctrl.tick && (over_limit != missing);

  always_ff @(posedge clk) begin
    if (rst) begin
      age        <= '0;
      tick_count <= '0;
      missing    <= 1'b0;
    end else if (ctrl.arrive) begin
      age <= '0;
    end else if (ctrl.tick) begin
      missing <= over_limit;
      if (expired) begin
        // reload past the limit at the ceiling, otherwise step
        if (age == cfg.age_ceiling) begin
          age <= cfg.age_limit + AgeW'(1);
        end else begin
          age <= age + AgeW'(1);
        end
        tick_count <= TickW'(1);
      end else begin
        tick_count <= tick_count + TickW'(1);
      end
    end
  end

endmodule

// ----- tb/sv/freshness_status_checker.sv -----
module freshness_status_checker
  import sfrm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [IntervalW-1:0] s_tdata,   // [23:0] publish_interval_us
  input  logic [1:0]           s_tuser,   // [1:0] action
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [OutDataW-1:0]  m_tdata,   // [1:0] rate_status, [2] rate_status_changed,
                                          // [5:3] missing_mask,
                                          // [8:6] missing_changed_mask, [15:9] zero
  output int                   mismatch_count,
  output int                   outstanding,
  output int                   words_checked
);

  // Layout of one result word, lowest field last.
  typedef struct packed {
    logic [6:0]            pad;
    logic [NumStreams-1:0] missing_changed;
    logic [NumStreams-1:0] missing;
    logic                  rate_changed;
    rate_t                 rate;
  } status_word_t;

  // Register copies.
  logic [IntervalW-1:0] expected_iv;
  logic [AgeW-1:0]      age_limit_r;
  logic [AgeW-1:0]      age_ceiling_r;
  logic [TickW-1:0]     tick_limit_r [NumStreams];

  // Watchdog state.
  rate_t                rate_now;
  logic [AgeW-1:0]      age [NumStreams];
  logic [TickW-1:0]     tick_cnt [NumStreams];
  logic [NumStreams-1:0] missing_now;

  status_word_t         pending_status_q [$];
  int                   errors;
  int                   checked;

  // Rate the publish interval; widen so that the scaled compares cannot overflow.
  function automatic rate_t rate_of(logic [IntervalW-1:0] interval);
    logic [31:0] iv;
    logic [31:0] ev;
    iv = 32'(interval);
    ev = 32'(expected_iv);
    if (iv > 2 * ev) return RATE_ERROR;
    if (10 * iv > 13 * ev) return RATE_WARNING;
    if (iv == 0) return RATE_UNKNOWN;
    return RATE_OK;
  endfunction

  // Advance the watchdog by one input word and return the status word it yields.
  function automatic status_word_t step_watchdog(action_t act,
                                                 logic [IntervalW-1:0] interval);
    status_word_t w;
    rate_t        r;
    w = '0;
    if (act != ACT_TICK) begin
      age[int'(act) - 1] = '0;
    end else begin
      r = rate_of(interval);
      if (r != rate_now) begin
        w.rate_changed = 1'b1;
        rate_now = r;
      end
      for (int i = 0; i < NumStreams; i++) begin
        if ((age[i] > age_limit_r) != missing_now[i]) begin
          w.missing_changed[i] = 1'b1;
          missing_now[i] = ~missing_now[i];
        end
      end
      for (int i = 0; i < NumStreams; i++) begin
        if (tick_cnt[i] > tick_limit_r[i]) begin
          age[i] = (age[i] == age_ceiling_r) ? age_limit_r + 8'd1 : age[i] + 8'd1;
          tick_cnt[i] = '0;
        end
        tick_cnt[i] = tick_cnt[i] + 16'd1;
      end
    end
    w.rate    = rate_now;
    w.missing = missing_now;
    return w;
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    status_word_t got;
    status_word_t want;
    if (rst) begin
      expected_iv   = RST_EXPECTED_INTERVAL;
      age_limit_r   = RST_AGE_LIMIT;
      age_ceiling_r = RST_AGE_CEILING;
      rate_now      = RATE_UNKNOWN;
      missing_now   = '0;
      for (int i = 0; i < NumStreams; i++) begin
        tick_limit_r[i] = RST_TICK_LIMIT;
        age[i]          = '0;
        tick_cnt[i]     = '0;
      end
      pending_status_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_EXPECTED_INTERVAL: expected_iv     = cfg_data[IntervalW-1:0];
          REG_AGE_LIMIT:         age_limit_r     = cfg_data[AgeW-1:0];
          REG_AGE_CEILING:       age_ceiling_r   = cfg_data[AgeW-1:0];
          REG_SOLUTION_LIMIT:    tick_limit_r[0] = cfg_data[TickW-1:0];
          REG_CORRECTION_LIMIT:  tick_limit_r[1] = cfg_data[TickW-1:0];
          REG_ATTITUDE_LIMIT:    tick_limit_r[2] = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_status_q.push_back(step_watchdog(action_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        got = status_word_t'(m_tdata);
        if (pending_status_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result word %h", m_tdata));
        end else begin
          want = pending_status_q.pop_front();
          checked++;
          if (got.rate !== want.rate || got.rate_changed !== want.rate_changed ||
              got.missing !== want.missing ||
              got.missing_changed !== want.missing_changed || got.pad !== '0)
            flag_mismatch($sformatf(
              "result %0d: expected rate %0d chg %b miss %b mchg %b | got rate %0d chg %b miss %b mchg %b pad %h",
              checked, want.rate, want.rate_changed, want.missing, want.missing_changed,
              got.rate, got.rate_changed, got.missing, got.missing_changed, got.pad));
        end
      end
    end
    mismatch_count <= errors;
    outstanding    <= pending_status_q.size();
    words_checked  <= checked;
  end

endmodule

// ----- tb/sv/tb_stream_freshness_rate_monitor.sv -----
module tb_stream_freshness_rate_monitor;
  import sfrm_pkg::*;

  // Result passes the input and result registers; pad the final wait a bit.
  localparam int DutLatency    = 2;
  // Long receiver stall, long enough to back the block up into its input.
  localparam int HoldoffCycles = 80;
  localparam int RandomPhases  = 8;
  localparam int WordsPerPhase = 66;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IntervalW-1:0] s_tdata   = '0;   // [23:0] publish_interval_us
  logic [1:0]           s_tuser   = '0;   // [1:0] action
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OutDataW-1:0]  m_tdata;          // [1:0] rate_status, [2] rate_status_changed,
                                          // [5:3] missing_mask,
                                          // [8:6] missing_changed_mask, [15:9] zero

  int mismatch_count;
  int outstanding;
  int words_checked;

  // Handshake flags between the sender and the receiver processes.
  bit holdoff_req = 1'b0;   // sender asks, receiver clears when it starts the stall
  bit burst_mode  = 1'b0;   // sender offers words back to back
  bit quiet_tail  = 1'b0;   // no idling on either side

  int                   words_sent      = 0;
  int                   settings_loaded = 0;
  logic [IntervalW-1:0] cur_expected    = RST_EXPECTED_INTERVAL;

  always #5 clk = ~clk;

  stream_freshness_rate_monitor i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  freshness_status_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .words_checked  (words_checked)
  );

  // Offer one word and hold it until the block takes it. A random gap may come
  // first; the word is raised only after the gap, never in the step that drops it.
  task automatic send_word(input action_t act, input logic [IntervalW-1:0] iv);
    if (!quiet_tail && !burst_mode && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= iv;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Drop valid and wait until every result word has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write the whole register file, spare indexes included. Call only when drained.
  task automatic load_settings(input logic [IntervalW-1:0] exp_iv,
                               input logic [AgeW-1:0] lim,
                               input logic [AgeW-1:0] ceil,
                               input logic [TickW-1:0] sol,
                               input logic [TickW-1:0] cor,
                               input logic [TickW-1:0] att);
    logic [CfgDataW-1:0] value;
    for (int idx = 0; idx < 8; idx++) begin
      case (CfgIndexW'(idx))
        REG_EXPECTED_INTERVAL: value = CfgDataW'(exp_iv);
        REG_AGE_LIMIT:         value = CfgDataW'(lim);
        REG_AGE_CEILING:       value = CfgDataW'(ceil);
        REG_SOLUTION_LIMIT:    value = CfgDataW'(sol);
        REG_CORRECTION_LIMIT:  value = CfgDataW'(cor);
        REG_ATTITUDE_LIMIT:    value = CfgDataW'(att);
        default:               value = CfgDataW'($urandom);
      endcase
      cfg_write <= 1'b1;
      cfg_index <= CfgIndexW'(idx);
      cfg_data  <= value;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_expected = exp_iv;
    settings_loaded++;
  endtask

  // Pick a tick limit: mostly small so that streams age fast, sometimes the top.
  function automatic logic [TickW-1:0] pick_tick_limit();
    case ($urandom_range(0, 9))
      0:       return 16'd65534;
      1:       return 16'd65535;
      2:       return TickW'($urandom);
      default: return TickW'($urandom_range(0, 3));
    endcase
  endfunction

  // Draw a random register set that leans toward the edges of each range.
  task automatic load_random_settings();
    logic [IntervalW-1:0] exp_iv;
    logic [AgeW-1:0]      lim;
    logic [AgeW-1:0]      ceil;
    case ($urandom_range(0, 5))
      0:       exp_iv = '0;
      1:       exp_iv = '1;
      2:       exp_iv = IntervalW'($urandom);
      default: exp_iv = IntervalW'($urandom_range(1, 5000));
    endcase
    case ($urandom_range(0, 7))
      0:       lim = 8'd0;
      1:       lim = 8'd254;
      2:       lim = 8'd255;
      default: lim = AgeW'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 7))
      0:       ceil = 8'd0;
      1:       ceil = 8'd1;
      2:       ceil = 8'd255;
      default: ceil = lim + AgeW'($urandom_range(0, 4));
    endcase
    load_settings(exp_iv, lim, ceil, pick_tick_limit(), pick_tick_limit(),
                  pick_tick_limit());
  endtask

  // Interval around the rating thresholds, or plain random; saturate to 24 bits.
  function automatic logic [IntervalW-1:0] pick_interval();
    logic [31:0] e;
    logic [31:0] v;
    e = 32'(cur_expected);
    case ($urandom_range(0, 6))
      0:       v = 0;
      1:       v = $urandom & 32'hFFFFFF;
      2:       v = e;
      3:       v = 2 * e + $urandom_range(0, 2) - 1;
      4:       v = (13 * e) / 10 + $urandom_range(0, 3) - 1;
      5:       v = (e * $urandom_range(0, 25)) / 10;
      default: v = $urandom_range(1, 3);
    endcase
    if (v > 32'hFFFFFF) v = 32'hFFFFFF;
    return v[IntervalW-1:0];
  endfunction

  // Receiver: random ready bursts, the long stall on request, none at the tail.
  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldoffCycles) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Sender and verdict.
  initial begin
    action_t act;
    int      arrive_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: expected interval zero, so any nonzero interval is an error.
    send_word(ACT_TICK, 24'd0);
    send_word(ACT_TICK, 24'd1);
    send_word(ACT_SOLUTION, 24'hFFFFFF);
    send_word(ACT_CORRECTION, 24'd0);
    send_word(ACT_ATTITUDE, 24'h5A5A5A);
    send_word(ACT_TICK, 24'd0);

    // Walk the rating thresholds; fast aging drives streams missing and wraps the age.
    drain();
    load_settings(24'd1000, 8'd1, 8'd3, 16'd0, 16'd0, 16'd0);
    send_word(ACT_TICK, 24'd1000);
    send_word(ACT_TICK, 24'd1300);
    send_word(ACT_TICK, 24'd1301);
    send_word(ACT_TICK, 24'd2000);
    send_word(ACT_TICK, 24'd2001);
    send_word(ACT_TICK, 24'hFFFFFF);
    send_word(ACT_TICK, 24'd0);
    send_word(ACT_SOLUTION, 24'd0);
    send_word(ACT_CORRECTION, 24'd0);
    send_word(ACT_TICK, 24'd999);
    send_word(ACT_TICK, 24'd999);

    // Top expected interval, age limit whose reload wraps to zero, wrap-only counter.
    drain();
    load_settings(24'hFFFFFF, 8'd255, 8'd2, 16'd0, 16'd65535, 16'd65534);
    send_word(ACT_TICK, 24'hFFFFFF);
    send_word(ACT_TICK, 24'd0);
    send_word(ACT_TICK, 24'd1);
    send_word(ACT_TICK, 24'h800000);
    send_word(ACT_TICK, 24'd7);

    // Random phases, each under a fresh register set.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain();
      load_random_settings();
      arrive_pct = $urandom_range(5, 60);
      quiet_tail = (phase == RandomPhases - 1);
      if (phase == 2) begin
        holdoff_req = 1'b1;
        burst_mode  = 1'b1;
      end
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (n == 40) burst_mode = 1'b0;
        if ($urandom_range(0, 99) < arrive_pct)
          act = action_t'($urandom_range(1, 3));
        else
          act = ACT_TICK;
        send_word(act, pick_interval());
      end
    end

    drain();
    repeat (DutLatency + 4) @(posedge clk);
    $display("covered %0d input words over %0d register sets, %0d results compared",
             words_sent, settings_loaded, words_checked);
    if (mismatch_count == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
